// ===== rtl/cfir_pkg.sv =====
// ----------------------------------------------------------------------------
// cfir_pkg
// Shared types and constants for the causal FIR filter: item layouts, codes
// for the item mode and configuration registers, and the control group that
// drives every tap cell.
// ----------------------------------------------------------------------------
package cfir_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 16;
  localparam int DEF_MAX_TAPS = 32;

  localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int CONTRIB_W = PROD_W + 1;

  localparam int TAP_CNT_W = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 6;

  // Item mode codes.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_FILTER = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX_MODE = 1'b1;

  typedef struct packed {
    logic                           mode;
    logic [4:0]                     coef_index;
    logic signed [COEF_WIDTH-1:0]   coef_re;
    logic signed [COEF_WIDTH-1:0]   coef_im;
    logic signed [SAMPLE_WIDTH-1:0] sample_re;
    logic signed [SAMPLE_WIDTH-1:0] sample_im;
    logic                           vector_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] out_re;
    logic signed [SAMPLE_WIDTH-1:0] out_im;
    logic                           saturated;
  } out_item_t;

  // Control group broadcast to the cells.
  typedef struct packed {
    logic shift;   // a sample enters the delay line
    logic clear;   // history before the new sample is dropped
    logic cmode;   // complex multiply-accumulate
  } cell_ctrl_t;

endpackage

// ===== rtl/cfir_cell.sv =====
// ----------------------------------------------------------------------------
// cfir_cell
// One tap of the filter: holds its history sample and coefficient, forms the
// registered products and adds its contribution to the partial sum that
// walks along the chain.
// ----------------------------------------------------------------------------
module cfir_cell
  import cfir_pkg::*;
#(
  parameter int ACC_W = 40
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cell_ctrl_t                     ctrl,
  input  logic                           active,
  input  logic                           tap_we,
  input  logic signed [COEF_WIDTH-1:0]   tap_re_in,
  input  logic signed [COEF_WIDTH-1:0]   tap_im_in,
  input  logic signed [SAMPLE_WIDTH-1:0] hist_re_in,
  input  logic signed [SAMPLE_WIDTH-1:0] hist_im_in,
  output logic signed [SAMPLE_WIDTH-1:0] hist_re_out,
  output logic signed [SAMPLE_WIDTH-1:0] hist_im_out,
  input  logic signed [ACC_W-1:0]        sum_re_in,
  input  logic signed [ACC_W-1:0]        sum_im_in,
  output logic signed [ACC_W-1:0]        sum_re_out,
  output logic signed [ACC_W-1:0]        sum_im_out
);

  logic signed [SAMPLE_WIDTH-1:0] hist_re_r, hist_im_r;
  logic signed [COEF_WIDTH-1:0]   tap_re_r, tap_im_r;
  logic signed [PROD_W-1:0]       rr_r, ii_r, ri_r, ir_r;
  logic signed [CONTRIB_W-1:0]    contrib_re_r, contrib_im_r;
  logic signed [ACC_W-1:0]        sum_re_r, sum_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_re_r <= '0;
      hist_im_r <= '0;
      tap_re_r  <= '0;
      tap_im_r  <= '0;
    end else begin
      if (ctrl.shift) begin
        hist_re_r <= ctrl.clear ? '0 : hist_re_in;
        hist_im_r <= ctrl.clear ? '0 : hist_im_in;
      end
      if (tap_we) begin
        tap_re_r <= tap_re_in;
        tap_im_r <= tap_im_in;
      end
    end
  end

  // Products, contribution and partial sum run freely; the controller waits
  // until the chain has settled after the last change of history or taps.
  always_ff @(posedge clk) begin
    rr_r <= tap_re_r * hist_re_r;
    ii_r <= tap_im_r * hist_im_r;
    ri_r <= tap_re_r * hist_im_r;
    ir_r <= tap_im_r * hist_re_r;
    if (ctrl.cmode) begin
      contrib_re_r <= CONTRIB_W'(rr_r) - CONTRIB_W'(ii_r);
      contrib_im_r <= CONTRIB_W'(ri_r) + CONTRIB_W'(ir_r);
    end else begin
      contrib_re_r <= CONTRIB_W'(rr_r);
      contrib_im_r <= '0;
    end
    sum_re_r <= sum_re_in + (active ? ACC_W'(contrib_re_r) : '0);
    sum_im_r <= sum_im_in + (active ? ACC_W'(contrib_im_r) : '0);
  end

  assign hist_re_out = hist_re_r;
  assign hist_im_out = hist_im_r;
  assign sum_re_out  = sum_re_r;
  assign sum_im_out  = sum_im_r;

endmodule

// ===== rtl/causal_fir_filter_top.sv =====
// ----------------------------------------------------------------------------
// causal_fir_filter_top
// Causal direct-form FIR filter on Q1.15 samples, real or complex, built as a
// chain of tap cells.
// ----------------------------------------------------------------------------
// A coefficient-load item gives no result, so loads may follow each other in
// every cycle while no sample item is in flight. A sample item enters the
// delay line on acceptance, and the input stays stalled until its result is
// registered, so no new item is taken until that sample is through: the
// partial sum walks the tap chain one cell per cycle, behind a product and a
// contribution register in every cell. A finished item waits in the output
// register while the next one is taken in; it holds the input stalled only if
// the following result is ready before the earlier one has been taken.
module causal_fir_filter_top
  import cfir_pkg::*;
#(
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int ACC_EXACT = SAMPLE_WIDTH + COEF_WIDTH + 3 + $clog2(MAX_TAPS + 1);
  localparam int ACC_W     = (ACC_EXACT > 64) ? 64 : ACC_EXACT;
  localparam int CNT_W     = $clog2(MAX_TAPS + 3);
  localparam logic [CNT_W-1:0] DONE_CNT = CNT_W'(MAX_TAPS + 2);

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'(1) << (COEF_WIDTH - 2));
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'((64'(1) << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [TAP_CNT_W-1:0]   tap_count_r;
  logic                   cmode_r;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r;

  logic                   in_acc, filt_acc, load_acc, done;
  cell_ctrl_t             ctrl;

  logic signed [SAMPLE_WIDTH-1:0] hist_re [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hist_im [MAX_TAPS];
  logic signed [ACC_W-1:0]        sum_re  [MAX_TAPS];
  logic signed [ACC_W-1:0]        sum_im  [MAX_TAPS];

  // Round half up by COEF_WIDTH-1 bits, saturate; top bit is the clip flag.
  function automatic logic [SAMPLE_WIDTH:0] finish(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] shr;
    logic [SAMPLE_WIDTH:0]   res;
    rnd = acc + RND_HALF;
    shr = rnd >>> (COEF_WIDTH - 1);
    if (shr > SAT_HI) begin
      res = {1'b1, SAT_HI[SAMPLE_WIDTH-1:0]};
    end else if (shr < SAT_LO) begin
      res = {1'b1, SAT_LO[SAMPLE_WIDTH-1:0]};
    end else begin
      res = {1'b0, shr[SAMPLE_WIDTH-1:0]};
    end
    return res;
  endfunction

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign filt_acc = in_acc && (in_item.mode == MODE_FILTER);
  assign load_acc = in_acc && (in_item.mode == MODE_LOAD);
  assign done     = (state_r == ST_RUN) && (cnt_r == DONE_CNT) &&
                    (!out_valid_r || !out_stall);

  assign ctrl.shift = filt_acc;
  assign ctrl.clear = in_item.vector_start;
  assign ctrl.cmode = cmode_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (filt_acc) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end else if (cnt_r != DONE_CNT) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = done || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      tap_count_r <= '0;
      cmode_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TAP_COUNT:    tap_count_r <= cfg_data[TAP_CNT_W-1:0];
          CFG_COMPLEX_MODE: cmode_r     <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [SAMPLE_WIDTH:0] fin_re;
    logic [SAMPLE_WIDTH:0] fin_im;
    fin_re = finish(sum_re[MAX_TAPS-1]);
    fin_im = finish(sum_im[MAX_TAPS-1]);
    if (done) begin
      out_item_r.out_re    <= fin_re[SAMPLE_WIDTH-1:0];
      out_item_r.out_im    <= cmode_r ? fin_im[SAMPLE_WIDTH-1:0] : '0;
      out_item_r.saturated <= fin_re[SAMPLE_WIDTH] || (cmode_r && fin_im[SAMPLE_WIDTH]);
    end
  end

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    cell_ctrl_t                     cell_ctrl;
    logic                           active;
    logic                           tap_we;
    logic signed [SAMPLE_WIDTH-1:0] hre_in, him_in;
    logic signed [ACC_W-1:0]        sre_in, sim_in;

    assign active = (32'(k) < 32'(tap_count_r));
    assign tap_we = load_acc && (32'(in_item.coef_index) == 32'(k));

    if (k == 0) begin : g_head
      // The newest sample enters here whether or not the vector restarts.
      always_comb begin
        cell_ctrl       = ctrl;
        cell_ctrl.clear = 1'b0;
      end
      assign hre_in = in_item.sample_re;
      assign him_in = in_item.sample_im;
      assign sre_in = '0;
      assign sim_in = '0;
    end else begin : g_body
      assign cell_ctrl = ctrl;
      assign hre_in    = hist_re[k-1];
      assign him_in    = hist_im[k-1];
      assign sre_in    = sum_re[k-1];
      assign sim_in    = sum_im[k-1];
    end

    cfir_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (cell_ctrl),
      .active      (active),
      .tap_we      (tap_we),
      .tap_re_in   (in_item.coef_re),
      .tap_im_in   (in_item.coef_im),
      .hist_re_in  (hre_in),
      .hist_im_in  (him_in),
      .hist_re_out (hist_re[k]),
      .hist_im_out (hist_im[k]),
      .sum_re_in   (sre_in),
      .sum_im_in   (sim_in),
      .sum_re_out  (sum_re[k]),
      .sum_im_out  (sum_im[k])
    );
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/cfir_checker.sv =====
// ----------------------------------------------------------------------------
// cfir_checker
// Port-level checks for the causal FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
module cfir_checker
  import cfir_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input in_item_t             in_item,
  input logic                 out_valid,
  input logic                 out_stall,
  input out_item_t            out_item
);

  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // A held result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // A sample item occupies the block; a load item does not.
  a_filter_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.mode == MODE_FILTER |=> in_stall)
    else $error("input not stalled after a sample item");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.mode == MODE_LOAD |=> !in_stall)
    else $error("input stalled after a coefficient load");

  // The block only frees its input once the result is on show.
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid)
    else $error("input freed without a result item");

  // A clipped result sits on a limit of the output range.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated |->
      out_item.out_re == OUT_MAX || out_item.out_re == OUT_MIN ||
      out_item.out_im == OUT_MAX || out_item.out_im == OUT_MIN)
    else $error("saturation flag set on an unclipped result");

endmodule

bind causal_fir_filter_top cfir_checker u_cfir_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for causal_fir_filter_top. Coefficient loads and
// samples are queued by a stimulus process and offered by a clocked driver.
// Every accepted item updates a local copy of the delay line and coefficient
// store, and each sample item's output is predicted there and compared field
// by field with what the monitor collects. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import cfir_pkg::*;

  localparam int MAX_TAPS     = DEF_MAX_TAPS;
  localparam int DRAIN_CYCLES = MAX_TAPS + 12;
  localparam int LONG_HOLD    = 400;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  causal_fir_filter_top #(.MAX_TAPS(MAX_TAPS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Local copy of the filter state and registers.
  logic signed [COEF_WIDTH-1:0]   coef_re_q [MAX_TAPS];
  logic signed [COEF_WIDTH-1:0]   coef_im_q [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hist_re_q [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hist_im_q [MAX_TAPS];
  logic [TAP_CNT_W-1:0]           taps_in_use;
  logic                           cplx_on;

  in_item_t  pending_items[$];
  out_item_t expected_outputs[$];
  out_item_t next_expected;

  int errors       = 0;
  int items_queued = 0;
  int tx_gap       = 0;
  int rx_gap       = 0;
  int hold_left    = 0;
  bit hold_kick    = 1'b0;
  bit tx_idle_en   = 1'b0;
  bit rx_idle_en   = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Round half up from Q2.30 to Q1.15 and clip; bit 16 flags clipping.
  function automatic logic [16:0] round_sat(input longint acc);
    longint v;
    logic   clipped;
    clipped = 1'b0;
    v = (acc + 64'sd16384) >>> 15;
    if (v > 32767) begin
      v = 32767;
      clipped = 1'b1;
    end else if (v < -32768) begin
      v = -32768;
      clipped = 1'b1;
    end
    return {clipped, v[15:0]};
  endfunction

  task automatic predict_item(input in_item_t it);
    longint      acc_re;
    longint      acc_im;
    logic [16:0] fin_re;
    logic [16:0] fin_im;
    int          n;
    out_item_t   r;
    if (it.mode == MODE_LOAD) begin
      coef_re_q[it.coef_index] = it.coef_re;
      coef_im_q[it.coef_index] = it.coef_im;
    end else begin
      if (it.vector_start) begin
        for (int k = 0; k < MAX_TAPS; k++) begin
          hist_re_q[k] = '0;
          hist_im_q[k] = '0;
        end
      end
      for (int k = MAX_TAPS - 1; k > 0; k--) begin
        hist_re_q[k] = hist_re_q[k-1];
        hist_im_q[k] = hist_im_q[k-1];
      end
      hist_re_q[0] = it.sample_re;
      hist_im_q[0] = it.sample_im;
      n = (taps_in_use > MAX_TAPS) ? MAX_TAPS : int'(taps_in_use);
      acc_re = 0;
      acc_im = 0;
      for (int k = 0; k < n; k++) begin
        acc_re += longint'(coef_re_q[k]) * longint'(hist_re_q[k]);
        if (cplx_on) begin
          acc_re -= longint'(coef_im_q[k]) * longint'(hist_im_q[k]);
          acc_im += longint'(coef_re_q[k]) * longint'(hist_im_q[k])
                  + longint'(coef_im_q[k]) * longint'(hist_re_q[k]);
        end
      end
      fin_re = round_sat(acc_re);
      fin_im = cplx_on ? round_sat(acc_im) : 17'd0;
      r.out_re    = fin_re[15:0];
      r.out_im    = fin_im[15:0];
      r.saturated = fin_re[16] | fin_im[16];
      expected_outputs.push_back(r);
    end
  endtask

  // Driver: the payload is held while stalled, gaps fall between items.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (in_valid && !in_stall)
        predict_item(in_item);
      if (!(in_valid && in_stall)) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          if (tx_idle_en && $urandom_range(0, 11) == 0) begin
            tx_gap   <= $urandom_range(1, 19) - 1;
            in_valid <= 1'b0;
          end else begin
            in_item  <= pending_items.pop_front();
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here and started by the stimulus process.
  always @(posedge clk) begin
    if (!rst_n)
      hold_left <= 0;
    else if (hold_kick && hold_left == 0)
      hold_left <= LONG_HOLD;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  // Monitor: check each accepted result, then decide the next stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap    <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_outputs.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected output item: re=%0d im=%0d sat=%0b",
                     out_item.out_re, out_item.out_im, out_item.saturated);
        end else begin
          next_expected = expected_outputs.pop_front();
          if (out_item.out_re !== next_expected.out_re ||
              out_item.out_im !== next_expected.out_im ||
              out_item.saturated !== next_expected.saturated) begin
            errors++;
            if (errors <= 10)
              $display("output mismatch: expected re=%0d im=%0d sat=%0b, got re=%0d im=%0d sat=%0b",
                       next_expected.out_re, next_expected.out_im, next_expected.saturated,
                       out_item.out_re, out_item.out_im, out_item.saturated);
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (rx_gap != 0) begin
        rx_gap    <= rx_gap - 1;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        rx_gap    <= $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int rand_q15(input int shift_max);
    logic signed [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 5))
      0: v = 16'sh7FFF;
      1: v = 16'sh8000;
      2: v = v >>> $urandom_range(0, shift_max);
      default: ;
    endcase
    return int'(v);
  endfunction

  task automatic push_load(input int idx, input int re, input int im);
    in_item_t it;
    it.mode         = MODE_LOAD;
    it.coef_index   = idx[4:0];
    it.coef_re      = re[15:0];
    it.coef_im      = im[15:0];
    it.sample_re    = 16'($urandom);
    it.sample_im    = 16'($urandom);
    it.vector_start = 1'($urandom_range(0, 1));
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_sample(input int re, input int im, input bit vs);
    in_item_t it;
    it.mode         = MODE_FILTER;
    it.coef_index   = 5'($urandom);
    it.coef_re      = 16'($urandom);
    it.coef_im      = 16'($urandom);
    it.sample_re    = re[15:0];
    it.sample_im    = im[15:0];
    it.vector_start = vs;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DAT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TAP_COUNT)
      taps_in_use = value[TAP_CNT_W-1:0];
    else
      cplx_on = value[0];
  endtask

  // Returns once every queued item has been taken and every output has come,
  // plus enough cycles for a trailing load to settle.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_outputs.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(input int tap_setting, input bit cplx, input int n_items,
                                  input bit tx_idle, input bit rx_idle, input bit long_hold);
    int start;
    int len;
    int cshift;
    write_cfg(CFG_TAP_COUNT, tap_setting);
    write_cfg(CFG_COMPLEX_MODE, ($urandom_range(0, 31) << 1) | int'(cplx));
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    start  = items_queued;
    cshift = $urandom_range(0, 10);
    // Usually a full coefficient set, sometimes only a few taps changed.
    if ($urandom_range(0, 2) != 0) begin
      for (int k = 0; k < MAX_TAPS; k++)
        push_load(k, rand_q15(cshift), rand_q15(cshift));
    end else begin
      repeat ($urandom_range(1, 6))
        push_load($urandom_range(0, MAX_TAPS - 1), rand_q15(cshift), rand_q15(cshift));
    end
    while (items_queued - start < n_items) begin
      push_sample(rand_q15(12), rand_q15(12), 1'b1);
      len = $urandom_range(1, 40);
      repeat (len) begin
        if ($urandom_range(0, 7) == 0)
          push_load($urandom_range(0, MAX_TAPS - 1), rand_q15(cshift), rand_q15(cshift));
        else
          push_sample(rand_q15(12), rand_q15(12), $urandom_range(0, 30) == 0);
      end
    end
    if (long_hold) begin
      @(posedge clk);
      hold_kick <= 1'b1;
      @(posedge clk);
      hold_kick <= 1'b0;
    end
    wait_drained();
  endtask

  initial begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      coef_re_q[k] = '0;
      coef_im_q[k] = '0;
      hist_re_q[k] = '0;
      hist_im_q[k] = '0;
    end
    taps_in_use = '0;
    cplx_on     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    // Registers as after reset: no taps in use, so every output is zero.
    push_sample(-32768, 32767, 1'b1);
    push_load(0, 32767, 32767);
    push_sample(32767, -32768, 1'b0);
    wait_drained();

    // One real tap: rounding half up in both directions, and the corner where
    // minus one times minus one clips.
    write_cfg(CFG_TAP_COUNT, 1);
    push_load(0, 1, 0);
    push_sample(16384, 0, 1'b1);
    push_sample(-16384, 0, 1'b0);
    push_load(0, -32768, -32768);
    push_sample(-32768, 7, 1'b1);
    push_sample(32767, -1, 1'b0);
    wait_drained();

    // Tap count above the store size, complex products at full scale.
    write_cfg(CFG_TAP_COUNT, 63);
    write_cfg(CFG_COMPLEX_MODE, 1);
    push_load(31, 32767, -32768);
    push_load(1, -32768, 32767);
    push_load(0, -32768, -32768);
    push_sample(-32768, -32768, 1'b1);
    push_sample(32767, 32767, 1'b0);
    push_sample(-32768, 32767, 1'b0);
    push_sample(0, 0, 1'b1);
    push_sample(32767, -32768, 1'b0);
    wait_drained();

    run_random_phase(32, 1'b0, 120, 1'b1, 1'b1, 1'b0);
    run_random_phase(0,  1'b1, 110, 1'b1, 1'b1, 1'b0);
    run_random_phase(32, 1'b1, 130, 1'b0, 1'b0, 1'b1);
    run_random_phase(63, 1'b0, 120, 1'b1, 1'b1, 1'b0);
    run_random_phase(5,  1'b1, 120, 1'b1, 1'b0, 1'b0);
    run_random_phase(1,  1'b0, 110, 1'b0, 1'b1, 1'b0);
    run_random_phase(40, 1'b1, 120, 1'b1, 1'b1, 1'b0);
    run_random_phase($urandom_range(0, 63), 1'($urandom_range(0, 1)), 120,
                     1'b1, 1'b1, 1'b0);
    // Final stretch runs without any idling.
    run_random_phase(17, 1'b1, 120, 1'b0, 1'b0, 1'b0);

    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
